// File: rtl/cnc_pkg.sv
// Shared types, codes and scan tables for the CAVLC nC context engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cnc_pkg;

	localparam int DEF_MAX_WIDTH_MBS  = 128;
	localparam int DEF_MAX_HEIGHT_MBS = 128;

	// Raster address of a macroblock: 7-bit row times 8-bit width plus column
	localparam int CUR_W = 15;

	typedef enum logic [1:0] {
		KIND_LUMA4X4   = 2'd0,
		KIND_LUMA_DC   = 2'd1,
		KIND_CHROMA_DC = 2'd2,
		KIND_CHROMA_AC = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CFG_FRAME_WIDTH  = 2'd0,
		CFG_FRAME_HEIGHT = 2'd1,
		CFG_SLICE_FIRST  = 2'd2
	} cfg_reg_t;

	localparam logic [1:0] CBPC_NONE   = 2'd0;
	localparam logic [1:0] CBPC_DC_AC  = 2'd2;

	localparam logic signed [5:0] NC_CHROMA_DC = -6'sd1;
	localparam logic [4:0]        COEFF_MAX    = 5'd16;

	localparam logic [1:0] SCAN_COL [16] = '{
		2'd0, 2'd1, 2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3,
		2'd0, 2'd1, 2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3
	};
	localparam logic [1:0] SCAN_ROW [16] = '{
		2'd0, 2'd0, 2'd1, 2'd1, 2'd0, 2'd0, 2'd1, 2'd1,
		2'd2, 2'd2, 2'd3, 2'd3, 2'd2, 2'd2, 2'd3, 2'd3
	};

	typedef struct packed {
		logic [6:0] mb_col;
		logic [6:0] mb_row;
		logic [1:0] kind;
		logic       chroma_comp;
		logic [3:0] block_index;
		logic [3:0] cbp_luma_bits;
		logic [1:0] cbp_chroma_code;
		logic [4:0] coeff_total;
	} in_item_t;

	typedef struct packed {
		logic signed [5:0] nc_value;
		logic              needs_decode;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CUR,
		ST_RD,
		ST_WB
	} state_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic calc;
		logic rd;
		logic wb;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic out_busy;
	} status_t;

	// 4x4 position inside a macroblock to luma scan index
	function automatic logic [3:0] pos_to_scan(input logic [1:0] x, input logic [1:0] y);
		return {y[1], x[1], y[0], x[0]};
	endfunction

endpackage

// File: rtl/cnc_ctrl.sv
// Sequencer for the nC context engine: clearing sweep, then one block per pass.
// Depends on cnc_pkg; drives cnc_datapath through cmd_t / status_t.
`timescale 1ns / 1ps

module cnc_ctrl import cnc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (status.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CUR;
				end
			end
			ST_CUR: begin
				cmd.calc = 1'b1;
				state_d  = ST_RD;
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_WB;
			end
			ST_WB: begin
				// hold until the output register can take the result
				if (!status.out_busy) begin
					cmd.wb  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_CUR))
		else $error("accepted transfer did not start a pass");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (!in_ready && !cmd.wb))
		else $error("activity during clearing sweep");

	a_wb_follows_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |=> (state_q == ST_WB))
		else $error("read not followed by writeback");

endmodule

// File: rtl/cnc_datapath.sv
// Datapath: config registers, address multiply, neighbour availability,
// luma/chroma count memories, nC combine and output register. Uses cnc_pkg.
`timescale 1ns / 1ps

module cnc_datapath import cnc_pkg::*; #(
	parameter int MAX_WIDTH_MBS  = DEF_MAX_WIDTH_MBS,
	parameter int MAX_HEIGHT_MBS = DEF_MAX_HEIGHT_MBS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	output status_t    status,
	input  in_item_t   in_data,
	input  logic       cfg_valid,
	input  logic [1:0] cfg_index,
	input  logic [13:0] cfg_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data
);

	localparam int MB_SLOTS     = MAX_WIDTH_MBS * MAX_HEIGHT_MBS;
	localparam int MB_AW        = (MB_SLOTS > 1) ? $clog2(MB_SLOTS) : 1;
	localparam int LUMA_DEPTH   = MB_SLOTS * 16;
	localparam int CHROMA_DEPTH = MB_SLOTS * 8;
	localparam int LUMA_AW      = MB_AW + 4;
	localparam int CHROMA_AW    = MB_AW + 3;

	logic [7:0]  fw_q, fh_q;
	logic [13:0] sf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= 8'd1;
			fh_q <= 8'd1;
			sf_q <= 14'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  fw_q <= cfg_data[7:0];
				CFG_FRAME_HEIGHT: fh_q <= cfg_data[7:0];
				CFG_SLICE_FIRST:  sf_q <= cfg_data;
				default: ;
			endcase
		end
	end

	in_item_t         item_q;
	logic [CUR_W-1:0] cur_q;

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= in_data;
		if (cmd.calc) cur_q <= CUR_W'(item_q.mb_row) * CUR_W'(fw_q) + CUR_W'(item_q.mb_col);
	end

	// Neighbour selection
	logic             is_ch;
	logic [3:0]       lblk, a_lblk, b_lblk;
	logic [1:0]       x4, y4, a_cblk, b_cblk;
	logic             cx, cy, int_a, int_b, left_ok, top_ok, a_ok, b_ok;
	logic [CUR_W-1:0] up_mb, a_mb, b_mb;
	logic [LUMA_AW-1:0]   la_idx, lb_idx;
	logic [CHROMA_AW-1:0] ca_idx, cb_idx;

	always_comb begin
		is_ch  = (item_q.kind == KIND_CHROMA_AC);
		lblk   = (item_q.kind == KIND_LUMA_DC) ? 4'd0 : item_q.block_index;
		x4     = SCAN_COL[lblk];
		y4     = SCAN_ROW[lblk];
		cx     = item_q.block_index[0];
		cy     = item_q.block_index[1];
		int_a  = is_ch ? cx : (x4 != 2'd0);
		int_b  = is_ch ? cy : (y4 != 2'd0);
		up_mb  = cur_q - CUR_W'(fw_q);
		left_ok = (item_q.mb_col != 7'd0) && ((8'(item_q.mb_col) - 8'd1) < fw_q)
			&& (8'(item_q.mb_row) < fh_q) && ((cur_q - CUR_W'(1)) >= CUR_W'(sf_q));
		top_ok  = (item_q.mb_row != 7'd0) && (8'(item_q.mb_col) < fw_q)
			&& ((8'(item_q.mb_row) - 8'd1) < fh_q) && (up_mb >= CUR_W'(sf_q));
		a_ok   = int_a || left_ok;
		b_ok   = int_b || top_ok;
		a_mb   = int_a ? cur_q : cur_q - CUR_W'(1);
		b_mb   = int_b ? cur_q : up_mb;
		// wrap of x4-1 / y4-1 picks column or row 3 of the neighbour macroblock
		a_lblk = pos_to_scan(x4 - 2'd1, y4);
		b_lblk = pos_to_scan(x4, y4 - 2'd1);
		a_cblk = {cy, ~cx};
		b_cblk = {~cy, cx};
		la_idx = {MB_AW'(a_mb), a_lblk};
		lb_idx = {MB_AW'(b_mb), b_lblk};
		ca_idx = {MB_AW'(a_mb), item_q.chroma_comp, a_cblk};
		cb_idx = {MB_AW'(b_mb), item_q.chroma_comp, b_cblk};
	end

	// Count memories and clearing sweep
	logic [4:0] luma_mem   [LUMA_DEPTH];
	logic [4:0] chroma_mem [CHROMA_DEPTH];
	logic [4:0] la_q, lb_q, ca_q, cb_q;
	logic       a_ok_q, b_ok_q, a_rng_q, b_rng_q;
	logic [LUMA_AW-1:0] clr_q;
	logic       cur_rng, wr_luma, wr_chroma;
	logic [4:0] store_val;
	logic [LUMA_AW-1:0]   lw_idx;
	logic [CHROMA_AW-1:0] cw_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr && !status.clr_done) begin
			clr_q <= clr_q + LUMA_AW'(1);
		end
	end

	assign status.clr_done = (clr_q == LUMA_AW'(LUMA_DEPTH - 1));

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			luma_mem[clr_q] <= 5'd0;
		end else if (wr_luma) begin
			luma_mem[lw_idx] <= store_val;
		end
		if (cmd.rd) begin
			la_q <= luma_mem[la_idx];
			lb_q <= luma_mem[lb_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr && (32'(clr_q) < CHROMA_DEPTH)) begin
			chroma_mem[CHROMA_AW'(clr_q)] <= 5'd0;
		end else if (wr_chroma) begin
			chroma_mem[cw_idx] <= store_val;
		end
		if (cmd.rd) begin
			ca_q <= chroma_mem[ca_idx];
			cb_q <= chroma_mem[cb_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			a_ok_q  <= a_ok;
			b_ok_q  <= b_ok;
			a_rng_q <= (32'(a_mb) < MB_SLOTS);
			b_rng_q <= (32'(b_mb) < MB_SLOTS);
		end
	end

	// Combine and result
	logic [4:0] na, nb, total_sat;
	logic [5:0] avg;
	logic       coded;
	out_item_t  res;

	always_comb begin
		na        = a_rng_q ? (is_ch ? ca_q : la_q) : 5'd0;
		nb        = b_rng_q ? (is_ch ? cb_q : lb_q) : 5'd0;
		avg       = (6'(na) + 6'(nb) + 6'd1) >> 1;
		total_sat = (item_q.coeff_total > COEFF_MAX) ? COEFF_MAX : item_q.coeff_total;
		coded     = 1'b0;
		unique case (item_q.kind)
			KIND_LUMA4X4:   coded = item_q.cbp_luma_bits[item_q.block_index[3:2]];
			KIND_LUMA_DC:   coded = 1'b1;
			KIND_CHROMA_DC: coded = (item_q.cbp_chroma_code != CBPC_NONE);
			KIND_CHROMA_AC: coded = (item_q.cbp_chroma_code == CBPC_DC_AC);
			default:        coded = 1'b0;
		endcase
		res.needs_decode = coded;
		if (item_q.kind == KIND_CHROMA_DC) begin
			res.nc_value = NC_CHROMA_DC;
		end else if (!coded) begin
			res.nc_value = 6'sd0;
		end else if (a_ok_q && b_ok_q) begin
			res.nc_value = $signed(avg);
		end else if (a_ok_q) begin
			res.nc_value = $signed(6'(na));
		end else if (b_ok_q) begin
			res.nc_value = $signed(6'(nb));
		end else begin
			res.nc_value = 6'sd0;
		end
		store_val = coded ? total_sat : 5'd0;
		cur_rng   = (32'(cur_q) < MB_SLOTS);
		wr_luma   = cmd.wb && cur_rng && (item_q.kind == KIND_LUMA4X4);
		wr_chroma = cmd.wb && cur_rng && is_ch;
		lw_idx    = {MB_AW'(cur_q), item_q.block_index};
		cw_idx    = {MB_AW'(cur_q), item_q.chroma_comp, item_q.block_index[1:0]};
	end

	logic      out_valid_q;
	out_item_t out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.wb) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wb) out_data_q <= res;
	end

	assign status.out_busy = out_valid_q && !out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_chroma_dc_nc: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wb && item_q.kind == KIND_CHROMA_DC) |=> (out_data_q.nc_value == NC_CHROMA_DC))
		else $error("chroma DC result without nC of -1");

	a_uncoded_nc: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_data_q.needs_decode) |->
		(out_data_q.nc_value == 6'sd0 || out_data_q.nc_value == NC_CHROMA_DC))
		else $error("uncoded block with nonzero nC");

	a_nc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q.nc_value <= 6'sd16))
		else $error("nC above 16");

endmodule

// File: rtl/cavlc_nc_context.sv
// CAVLC nC context engine for 4:2:0 residual blocks. Each input transfer
// names one residual block; one result transfer returns its nC and whether
// it is coded. A block passes in turn through accept, raster-address multiply,
// neighbour read, and combine and count write, which holds while the output
// register is full; the read of the count memories is registered. A finished
// result waits in an output register while the next block is accepted.
// After reset a clearing sweep zeroes the count memories, one luma entry per
// cycle, during which no block is accepted; configuration writes are taken at
// any time.
// Depends on cnc_pkg, cnc_ctrl and cnc_datapath.
`timescale 1ns / 1ps

module cavlc_nc_context import cnc_pkg::*; #(
	parameter int MAX_WIDTH_MBS  = DEF_MAX_WIDTH_MBS,
	parameter int MAX_HEIGHT_MBS = DEF_MAX_HEIGHT_MBS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [13:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	cnc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	cnc_datapath #(
		.MAX_WIDTH_MBS  (MAX_WIDTH_MBS),
		.MAX_HEIGHT_MBS (MAX_HEIGHT_MBS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: dv/cavlc_nc_context_chk.sv
// Checker for the CAVLC nC context engine: watches the item, result and
// register channels, predicts nC and the coded flag, and counts mismatches.
// Depends on cnc_pkg.
`timescale 1ns / 1ps

module cavlc_nc_context_chk import cnc_pkg::*; (
	input  logic        clk,
	input  logic        in_valid,
	input  logic        in_ready,
	input  in_item_t    in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  out_item_t   out_data,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [13:0] cfg_data,
	output int          errors,
	output int          pending,
	output int          results_seen
);

	localparam int MB_SLOTS = DEF_MAX_WIDTH_MBS * DEF_MAX_HEIGHT_MBS;

	int fw, fh, sf;
	logic [4:0] luma_cnt   [MB_SLOTS*16];
	logic [4:0] chroma_cnt [MB_SLOTS*8];
	out_item_t  nc_q [$];

	initial begin
		fw = 1;
		fh = 1;
		sf = 0;
		errors = 0;
		pending = 0;
		results_seen = 0;
		for (int i = 0; i < MB_SLOTS*16; i++) luma_cnt[i] = '0;
		for (int i = 0; i < MB_SLOTS*8; i++) chroma_cnt[i] = '0;
	end

	function automatic bit mb_avail(int x, int y, int cur);
		int a;
		if (x < 0 || y < 0 || x >= fw || y >= fh)
			return 0;
		a = y * fw + x;
		return a >= sf && a < cur;
	endfunction

	function automatic int scan_of(int x, int y);
		return ((y >> 1) << 3) | ((x >> 1) << 2) | ((y & 1) << 1) | (x & 1);
	endfunction

	function automatic int luma_get(int mb, int blk);
		return (mb >= MB_SLOTS) ? 0 : int'(luma_cnt[mb*16 + blk]);
	endfunction

	function automatic int chroma_get(int mb, int comp, int blk);
		return (mb >= MB_SLOTS) ? 0 : int'(chroma_cnt[(mb*2 + comp)*4 + blk]);
	endfunction

	function automatic int merge_nc(bit a_ok, int na, bit b_ok, int nb);
		if (a_ok && b_ok) return (na + nb + 1) >> 1;
		if (a_ok) return na;
		if (b_ok) return nb;
		return 0;
	endfunction

	function automatic int luma_nc(int col, int row, int cur, int blk);
		int x4, y4, na, nb;
		bit a_ok, b_ok;
		x4 = SCAN_COL[blk];
		y4 = SCAN_ROW[blk];
		na = 0;
		nb = 0;
		if (x4 > 0) begin
			a_ok = 1;
			na = luma_get(cur, scan_of(x4 - 1, y4));
		end else begin
			a_ok = mb_avail(col - 1, row, cur);
			if (a_ok) na = luma_get(cur - 1, scan_of(3, y4));
		end
		if (y4 > 0) begin
			b_ok = 1;
			nb = luma_get(cur, scan_of(x4, y4 - 1));
		end else begin
			b_ok = mb_avail(col, row - 1, cur);
			if (b_ok) nb = luma_get(cur - fw, scan_of(x4, 3));
		end
		return merge_nc(a_ok, na, b_ok, nb);
	endfunction

	function automatic int chroma_nc(int col, int row, int cur, int comp, int blk);
		int cx, cy, na, nb;
		bit a_ok, b_ok;
		cx = blk & 1;
		cy = (blk >> 1) & 1;
		na = 0;
		nb = 0;
		if (cx > 0) begin
			a_ok = 1;
			na = chroma_get(cur, comp, blk - 1);
		end else begin
			a_ok = mb_avail(col - 1, row, cur);
			if (a_ok) na = chroma_get(cur - 1, comp, cy*2 + 1);
		end
		if (cy > 0) begin
			b_ok = 1;
			nb = chroma_get(cur, comp, blk - 2);
		end else begin
			b_ok = mb_avail(col, row - 1, cur);
			if (b_ok) nb = chroma_get(cur - fw, comp, 2 + cx);
		end
		return merge_nc(a_ok, na, b_ok, nb);
	endfunction

	// Predict one block and update the count stores
	function automatic out_item_t block_context(in_item_t it);
		out_item_t r;
		int col, row, cur, tot, blk, cb;
		col = it.mb_col;
		row = it.mb_row;
		cur = row * fw + col;
		tot = (it.coeff_total > COEFF_MAX) ? int'(COEFF_MAX) : int'(it.coeff_total);
		blk = it.block_index;
		cb = blk & 3;
		r.nc_value = '0;
		r.needs_decode = 1'b0;
		case (kind_t'(it.kind))
			KIND_LUMA4X4: begin
				if (it.cbp_luma_bits[blk >> 2]) begin
					r.needs_decode = 1'b1;
					r.nc_value = 6'(luma_nc(col, row, cur, blk));
				end else begin
					tot = 0;
				end
				if (cur < MB_SLOTS) luma_cnt[cur*16 + blk] = 5'(tot);
			end
			KIND_LUMA_DC: begin
				r.needs_decode = 1'b1;
				r.nc_value = 6'(luma_nc(col, row, cur, 0));
			end
			KIND_CHROMA_DC: begin
				r.needs_decode = (it.cbp_chroma_code != CBPC_NONE);
				r.nc_value = NC_CHROMA_DC;
			end
			default: begin
				if (it.cbp_chroma_code == CBPC_DC_AC) begin
					r.needs_decode = 1'b1;
					r.nc_value = 6'(chroma_nc(col, row, cur, it.chroma_comp, cb));
				end else begin
					tot = 0;
				end
				if (cur < MB_SLOTS) chroma_cnt[(cur*2 + it.chroma_comp)*4 + cb] = 5'(tot);
			end
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		out_item_t want;
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:  fw = cfg_data[7:0];
				CFG_FRAME_HEIGHT: fh = cfg_data[7:0];
				CFG_SLICE_FIRST:  sf = cfg_data;
				default: ;
			endcase
		end
		if (in_valid && in_ready)
			nc_q.push_back(block_context(in_data));
		if (out_valid && out_ready) begin
			results_seen++;
			if (nc_q.size() == 0) begin
				$error("result with nothing expected: nc_value %0d", out_data.nc_value);
				errors++;
			end else begin
				want = nc_q.pop_front();
				if (out_data.nc_value !== want.nc_value) begin
					$error("nc_value: expected %0d, got %0d", want.nc_value, out_data.nc_value);
					errors++;
				end
				if (out_data.needs_decode !== want.needs_decode) begin
					$error("needs_decode: expected %0d, got %0d",
						want.needs_decode, out_data.needs_decode);
					errors++;
				end
			end
		end
		pending = nc_q.size();
	end

endmodule

// File: dv/cavlc_nc_context_tb.sv
// Top of the CAVLC nC context engine bench: clock, reset, stimulus and verdict.
// Depends on cnc_pkg, cavlc_nc_context and cavlc_nc_context_chk.
`timescale 1ns / 1ps

module cavlc_nc_context_tb import cnc_pkg::*;;

	localparam logic [1:0] CFG_SPARE = 2'd3;
	localparam int STALL_LIMIT = 1000000;
	localparam int N_ITEMS = 1900;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 0;
	out_item_t   out_data;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [13:0] cfg_data = '0;
	int          errors, pending, results_seen;
	int          n_sent = 0;
	int          n_mbs = 0;
	bit          idle_on = 1;
	bit          long_hold = 0;

	cavlc_nc_context uut (.*);

	cavlc_nc_context_chk chk (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// Receiver: random stall bursts plus one long hold-off
	initial begin
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				long_hold = 0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Watchdog: cycles without any transfer
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	function automatic in_item_t blk_item(int col, int row, kind_t k, int comp, int blk,
		int cbpl, int cbpc, int tot);
		in_item_t it;
		it.mb_col = 7'(col);
		it.mb_row = 7'(row);
		it.kind = k;
		it.chroma_comp = 1'(comp);
		it.block_index = 4'(blk);
		it.cbp_luma_bits = 4'(cbpl);
		it.cbp_chroma_code = 2'(cbpc);
		it.coeff_total = 5'(tot);
		return it;
	endfunction

	task automatic send(in_item_t it);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		n_sent++;
	endtask

	task automatic write_reg(logic [1:0] idx, int val);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 14'(val);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic frame_setup(int w, int h, int s);
		write_reg(CFG_FRAME_WIDTH, w);
		write_reg(CFG_FRAME_HEIGHT, h);
		write_reg(CFG_SLICE_FIRST, s);
	endtask

	task automatic noise_item();
		in_item_t it;
		it = in_item_t'($urandom);
		send(it);
	endtask

	// One macroblock in decoding order with random content
	task automatic send_mb(int col, int row);
		int cbpl, cbpc;
		cbpl = $urandom_range(0, 15);
		cbpc = $urandom_range(0, 2);
		n_mbs++;
		if ($urandom_range(0, 2) == 0)
			send(blk_item(col, row, KIND_LUMA_DC, 0, $urandom_range(0, 15), cbpl, cbpc,
				$urandom_range(0, 16)));
		for (int b = 0; b < 16; b++)
			send(blk_item(col, row, KIND_LUMA4X4, 0, b, cbpl, cbpc, $urandom_range(0, 16)));
		for (int c = 0; c < 2; c++)
			send(blk_item(col, row, KIND_CHROMA_DC, c, 0, cbpl, cbpc, $urandom_range(0, 16)));
		for (int c = 0; c < 2; c++)
			for (int b = 0; b < 4; b++)
				send(blk_item(col, row, KIND_CHROMA_AC, c, b, cbpl, cbpc,
					$urandom_range(0, 16)));
		if ($urandom_range(0, 3) == 0) noise_item();
	endtask

	initial begin
		int w, h, s, addr, p;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single-MB frame, saturation, uncoded and odd chroma codes
		frame_setup(1, 1, 0);
		write_reg(CFG_SPARE, 14'h3FFF);
		send(blk_item(0, 0, KIND_LUMA4X4, 0, 0, 15, 2, 31));
		send(blk_item(0, 0, KIND_LUMA4X4, 0, 1, 15, 2, 16));
		send(blk_item(0, 0, KIND_LUMA4X4, 0, 2, 15, 2, 0));
		send(blk_item(0, 0, KIND_LUMA4X4, 0, 3, 15, 2, 7));
		send(blk_item(0, 0, KIND_LUMA4X4, 0, 15, 15, 2, 17));
		send(blk_item(0, 0, KIND_LUMA4X4, 0, 5, 14, 2, 9));
		send(blk_item(0, 0, KIND_LUMA_DC, 0, 9, 0, 0, 3));
		send(blk_item(0, 0, KIND_CHROMA_DC, 0, 0, 0, 0, 4));
		send(blk_item(0, 0, KIND_CHROMA_DC, 1, 0, 0, 1, 4));
		send(blk_item(0, 0, KIND_CHROMA_DC, 1, 0, 0, 3, 4));
		send(blk_item(0, 0, KIND_CHROMA_AC, 0, 0, 0, 2, 31));
		send(blk_item(0, 0, KIND_CHROMA_AC, 0, 1, 0, 2, 5));
		send(blk_item(0, 0, KIND_CHROMA_AC, 1, 7, 0, 2, 12));
		send(blk_item(0, 0, KIND_CHROMA_AC, 1, 3, 0, 3, 12));
		send(blk_item(0, 0, KIND_CHROMA_AC, 1, 2, 0, 1, 12));
		send(blk_item(0, 0, KIND_CHROMA_AC, 1, 3, 0, 2, 1));
		send(blk_item(127, 127, KIND_LUMA4X4, 0, 10, 15, 2, 8));
		send(blk_item(127, 127, KIND_CHROMA_AC, 1, 2, 0, 2, 8));

		// Largest frame with a slice near the end of the store, then 0- and 255-wide frames
		frame_setup(128, 128, 16380);
		long_hold = 1;
		for (int a = 16380; a < 16384; a++) send_mb(a % 128, a / 128);
		frame_setup(0, 5, 0);
		for (int i = 0; i < 20; i++) noise_item();
		frame_setup(255, 255, 0);
		for (int i = 0; i < 30; i++) noise_item();

		p = 0;
		while (n_sent < N_ITEMS) begin
			case (p % 5)
				0: begin w = 4; h = 3; s = 0; end
				1: begin w = 3; h = 5; s = 2; end
				2: begin w = 7; h = 6; s = $urandom_range(0, 20); end
				3: begin w = 128; h = 2; s = 126; end
				default: begin w = $urandom_range(1, 9); h = $urandom_range(1, 4); s = 1; end
			endcase
			if (n_sent > N_ITEMS * 85 / 100) idle_on = 0;
			frame_setup(w, h, s);
			addr = s;
			while (addr < w * h && addr < s + 8 && n_sent < N_ITEMS) begin
				send_mb(addr % w, addr / w);
				addr++;
			end
			p++;
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d blocks (%0d whole macroblocks) and checked %0d results", n_sent,
			n_mbs, results_seen);
		$display("Frames from 0 to 255 MBs wide, slice starts at edges, saturated and uncoded");
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: files.f
rtl/cnc_pkg.sv
rtl/cnc_ctrl.sv
rtl/cnc_datapath.sv
rtl/cavlc_nc_context.sv
dv/cavlc_nc_context_chk.sv
dv/cavlc_nc_context_tb.sv
